// ===== src/idm_pkg.sv =====
// ============================================================================
// idm_pkg
// Shared types and constants of the car-following speed block: fixed-point
// format, register layout, datapath command and status words, and states.
// ============================================================================
`default_nettype none

package idm_pkg;

  // Fixed-point format: all speeds, gaps and times carry this many
  // fraction bits.
  localparam int FRAC_BITS = 8;
  localparam int ONE       = 1 << FRAC_BITS;

  // Shared multiplier: operand A is split into two halves, taken one after the other.
  localparam int MUL_AW = 48;
  localparam int MUL_HW = 24;
  localparam int MUL_BW = 26;
  localparam int MUL_PW = 62;

  // Shared divider: restoring, one quotient bit per cycle.
  localparam int DIV_DW = 52;
  localparam int DIV_VW = 24;
  localparam int DIV_CW = $clog2(DIV_DW + 1);

  localparam int CFG_DW = 14;
  localparam int CFG_IW = 3;

  typedef enum logic [CFG_IW-1:0] {
    REG_MAX_ACCEL,
    REG_BRAKE_TERM,
    REG_HEADWAY_TIME,
    REG_ACCEL_EXPONENT,
    REG_MIN_GAP,
    REG_STEP_LENGTH,
    REG_SUBSTEPS,
    REG_ADAPTATION
  } cfg_index_t;

  typedef struct packed {
    logic [11:0] max_accel;
    logic [13:0] brake_term;
    logic [11:0] headway_time;
    logic [3:0]  accel_exponent;
    logic [12:0] min_gap;
    logic [11:0] step_length;
    logic [4:0]  substeps;
    logic [9:0]  adaptation_factor;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FAC,
    OP_HW,
    OP_VH,
    OP_VVL,
    OP_DIV_BRAKE,
    OP_DIV_Q,
    OP_DIV_R,
    OP_P_INIT,
    OP_PR,
    OP_QQ,
    OP_ACC,
    OP_ACC_TS,
    OP_DIV_DV,
    OP_ADV_TS,
    OP_DIV_ADV,
    OP_RES_STOP,
    OP_RES_CLOSED,
    OP_RES_FINAL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   mul_start;
    logic   div_start;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic stop_near;
    logic gap_zero;
    logic steps_done;
    logic pow_done;
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FAC,
    ST_HW,
    ST_CHECK,
    ST_VH,
    ST_VVL,
    ST_BRAKE,
    ST_Q,
    ST_R,
    ST_PINIT,
    ST_POW,
    ST_QQ,
    ST_ACC,
    ST_ACC_TS,
    ST_DV,
    ST_ADV_TS,
    ST_ADV,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== src/idm_mul.sv =====
// ============================================================================
// idm_mul
// Unsigned multiplier: the wide operand is taken in two halves, one after the other.
// ============================================================================
`default_nettype none

module idm_mul (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [idm_pkg::MUL_AW-1:0] a,
  input  wire logic [idm_pkg::MUL_BW-1:0] b,
  output logic                           done,
  output logic [idm_pkg::MUL_PW-1:0]     prod
);
  import idm_pkg::*;

  localparam int PART_W = MUL_HW + MUL_BW;

  logic [MUL_AW-1:0]        a_r;
  logic [MUL_BW-1:0]        b_r;
  logic                     busy;
  logic                     phase;
  logic [MUL_HW+MUL_BW-1:0] partial;

  assign partial = PART_W'(phase ? a_r[MUL_AW-1:MUL_HW] : a_r[MUL_HW-1:0]) * PART_W'(b_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= busy & phase;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      if (phase) begin
        prod <= prod + MUL_PW'({partial, {MUL_HW{1'b0}}});
      end else begin
        prod <= MUL_PW'(partial);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/idm_div.sv =====
// ============================================================================
// idm_div
// Restoring unsigned divider producing one quotient bit per cycle.
// ============================================================================
`default_nettype none

module idm_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [idm_pkg::DIV_DW-1:0] dividend,
  input  wire logic [idm_pkg::DIV_VW-1:0] divisor,
  output logic                           done,
  output logic [idm_pkg::DIV_DW-1:0]     quot
);
  import idm_pkg::*;

  logic [DIV_VW-1:0] rem;
  logic [DIV_VW-1:0] dvs;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [DIV_VW:0]   shifted;
  logic              fits;

  assign shifted = {rem, quot[DIV_DW-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      quot <= dividend;
    end else if (busy) begin
      rem  <= fits ? DIV_VW'(shifted - {1'b0, dvs}) : shifted[DIV_VW-1:0];
      quot <= {quot[DIV_DW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== src/idm_dp.sv =====
// ============================================================================
// idm_dp
// Datapath: query and working registers, operand selection for the shared
// multiplier and divider, write-back of each step, and the output register.
// ============================================================================
`default_nettype none

module idm_dp #(
  parameter int MAX_SUBSTEPS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire idm_pkg::cfg_t     cfg,
  input  wire idm_pkg::dp_cmd_t  cmd,
  output idm_pkg::dp_stat_t      stat,
  input  wire logic              cmd_in,
  input  wire logic [15:0]       ego_speed,
  input  wire logic signed [23:0] gap_ahead,
  input  wire logic [15:0]       leader_speed,
  input  wire logic [15:0]       desired_speed,
  input  wire logic [8:0]        service_level,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [15:0]            next_speed,
  output logic                   gap_closed
);
  import idm_pkg::*;

  localparam int NW = $clog2(MAX_SUBSTEPS + 1);

  function automatic logic [MUL_AW-1:0] mag_of(input logic signed [MUL_AW-1:0] x);
    mag_of = x[MUL_AW-1] ? MUL_AW'(-x) : MUL_AW'(x);
  endfunction

  // Query and working registers.
  logic                stop_r;
  logic signed [31:0]  gap_r;
  logic signed [25:0]  v_r;
  logic [15:0]         lead_r;
  logic [15:0]         des_r;
  logic [8:0]          los_r;
  logic [18:0]         fac_r;
  logic [14:0]         h_r;
  logic signed [32:0]  t1_r;
  logic [DIV_DW-1:0]   tmp_mag;
  logic                tmp_neg;
  logic [31:0]         s_r;
  logic [24:0]         q_r;
  logic signed [21:0]  r_r;
  logic signed [41:0]  p_r;
  logic [3:0]          k_r;
  logic signed [43:0]  x_r;
  logic signed [46:0]  acc_r;
  logic [NW-1:0]       step_cnt;
  logic [15:0]         res_speed;
  logic                res_closed;

  // Unit connections.
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic              mul_neg;
  logic              mul_done;
  logic [MUL_PW-1:0] mul_prod;
  logic [MUL_PW-1:0] prod_sh;
  logic [DIV_DW-1:0] div_dvd;
  logic [DIV_VW-1:0] div_dvs;
  logic              div_done;
  logic [DIV_DW-1:0] quot;

  // Derived values.
  logic [NW-1:0]        n_val;
  logic [13:0]          brake_d;
  logic [12:0]          mgap;
  logic signed [26:0]   vl;
  logic [MUL_AW-1:0]    v_mag;
  logic signed [11:0]   af_diff;
  logic signed [21:0]   los_term;
  logic signed [21:0]   fac_s;
  logic [30:0]          hw_prod;
  logic signed [53:0]   quot_s;
  logic signed [53:0]   s_sum;
  logic [30:0]          s_clamp;
  logic signed [53:0]   v_sum;
  logic signed [25:0]   v_sat;
  logic [20:0]          r_mag;
  logic [40:0]          p_mag;

  always_comb begin
    if (cfg.substeps == '0) begin
      n_val = NW'(1);
    end else if (int'(cfg.substeps) > MAX_SUBSTEPS) begin
      n_val = NW'(MAX_SUBSTEPS);
    end else begin
      n_val = NW'(cfg.substeps);
    end
  end

  assign brake_d = (cfg.brake_term == '0) ? 14'd1 : cfg.brake_term;
  assign mgap    = stop_r ? '0 : cfg.min_gap;
  assign vl      = 27'(v_r) - 27'($signed({1'b0, lead_r}));
  assign v_mag   = mag_of(MUL_AW'(v_r));
  assign prod_sh = mul_prod >> FRAC_BITS;

  // Headway blend with the level of service.
  assign af_diff  = 12'(ONE) - $signed({2'b0, cfg.adaptation_factor});
  assign los_term = 22'($signed({1'b0, los_r})) * 22'(af_diff);
  assign fac_s    = los_term + 22'($signed({1'b0, cfg.adaptation_factor, {FRAC_BITS{1'b0}}}));
  assign hw_prod  = 31'(cfg.headway_time) * 31'(fac_r);

  // Signed view of the divider result, using the stored sign.
  assign quot_s = tmp_neg ? -$signed({2'b0, quot}) : $signed({2'b0, quot});

  // Safe distance: clamp to the positive 31-bit range.
  assign s_sum = quot_s + 54'(t1_r);
  always_comb begin
    if (s_sum < 54'sd0) begin
      s_clamp = '0;
    end else if (s_sum > 54'sd2147483647) begin
      s_clamp = '1;
    end else begin
      s_clamp = s_sum[30:0];
    end
  end

  // Speed update with saturation.
  assign v_sum = quot_s + 54'(v_r);
  always_comb begin
    if (v_sum > 54'sd16777216) begin
      v_sat = 26'sd16777216;
    end else if (v_sum < -54'sd16777216) begin
      v_sat = -26'sd16777216;
    end else begin
      v_sat = v_sum[25:0];
    end
  end

  assign r_mag = (quot > DIV_DW'(1 << 20)) ? 21'(1 << 20) : quot[20:0];
  assign p_mag = (prod_sh > (MUL_PW'(1) << 40)) ? (41'(1) << 40) : prod_sh[40:0];

  // Operand selection for the multiplier.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cmd.op)
      OP_VH: begin
        mul_a   = v_mag;
        mul_b   = MUL_BW'(h_r);
        mul_neg = v_r[25];
      end
      OP_VVL: begin
        mul_a   = v_mag;
        mul_b   = MUL_BW'(mag_of(MUL_AW'(vl)));
        mul_neg = v_r[25] ^ vl[26];
      end
      OP_PR: begin
        mul_a   = mag_of(MUL_AW'(p_r));
        mul_b   = MUL_BW'(mag_of(MUL_AW'(r_r)));
        mul_neg = p_r[41] ^ r_r[21];
      end
      OP_QQ: begin
        mul_a = MUL_AW'(q_r);
        mul_b = MUL_BW'(q_r);
      end
      OP_ACC: begin
        mul_a   = mag_of(MUL_AW'(x_r));
        mul_b   = MUL_BW'(cfg.max_accel);
        mul_neg = x_r[43];
      end
      OP_ACC_TS: begin
        mul_a   = mag_of(MUL_AW'(acc_r));
        mul_b   = MUL_BW'(cfg.step_length);
        mul_neg = acc_r[46];
      end
      OP_ADV_TS: begin
        mul_a   = mag_of(MUL_AW'(vl));
        mul_b   = MUL_BW'(cfg.step_length);
        mul_neg = vl[26];
      end
      default: begin
      end
    endcase
  end

  // Operand selection for the divider.
  always_comb begin
    div_dvd = tmp_mag;
    div_dvs = DIV_VW'(n_val);
    case (cmd.op)
      OP_DIV_BRAKE: div_dvs = DIV_VW'(brake_d);
      OP_DIV_Q: begin
        div_dvd = DIV_DW'({s_r, {FRAC_BITS{1'b0}}});
        div_dvs = gap_r[DIV_VW-1:0];
      end
      OP_DIV_R: begin
        div_dvd = DIV_DW'({v_mag[24:0], {FRAC_BITS{1'b0}}});
        div_dvs = DIV_VW'(des_r);
      end
      default: begin
      end
    endcase
  end

  idm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  idm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (quot)
  );

  // Write-back of each step.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        stop_r   <= cmd_in;
        gap_r    <= 32'(gap_ahead);
        v_r      <= 26'($signed({1'b0, ego_speed}));
        lead_r   <= cmd_in ? '0 : leader_speed;
        des_r    <= (desired_speed == '0) ? 16'd1 : desired_speed;
        los_r    <= service_level;
        step_cnt <= '0;
      end
      OP_FAC: fac_r <= fac_s[21] ? '0 : fac_s[18:0];
      OP_HW:  h_r   <= 15'(hw_prod >> (2 * FRAC_BITS));
      OP_VH: begin
        if (mul_done) begin
          t1_r <= mul_neg ? -33'(prod_sh) : 33'(prod_sh);
        end
      end
      OP_VVL: begin
        if (mul_done) begin
          tmp_mag <= DIV_DW'(mul_prod);
          tmp_neg <= mul_neg;
        end
      end
      OP_DIV_BRAKE: begin
        if (div_done) begin
          s_r <= 32'(s_clamp) + 32'(mgap);
        end
      end
      OP_DIV_Q: begin
        if (div_done) begin
          q_r <= (quot > DIV_DW'(1 << 24)) ? 25'(1 << 24) : quot[24:0];
        end
      end
      OP_DIV_R: begin
        if (div_done) begin
          r_r <= v_r[25] ? -22'(r_mag) : 22'(r_mag);
        end
      end
      OP_P_INIT: begin
        p_r <= 42'(ONE);
        k_r <= '0;
      end
      OP_PR: begin
        if (mul_done) begin
          p_r <= mul_neg ? -42'(p_mag) : 42'(p_mag);
          k_r <= k_r + 1'b1;
        end
      end
      OP_QQ: begin
        if (mul_done) begin
          x_r <= 44'(ONE) - 44'(p_r) - 44'($signed({1'b0, prod_sh[40:0]}));
        end
      end
      OP_ACC: begin
        if (mul_done) begin
          acc_r <= mul_neg ? -47'(prod_sh) : 47'(prod_sh);
        end
      end
      OP_ACC_TS, OP_ADV_TS: begin
        if (mul_done) begin
          tmp_mag <= DIV_DW'(prod_sh);
          tmp_neg <= mul_neg;
        end
      end
      OP_DIV_DV: begin
        if (div_done) begin
          v_r <= v_sat;
        end
      end
      OP_DIV_ADV: begin
        if (div_done) begin
          if (!tmp_neg && quot != '0) begin
            gap_r <= gap_r - 32'(quot);
          end
          step_cnt <= step_cnt + 1'b1;
        end
      end
      OP_RES_STOP: begin
        res_speed  <= '0;
        res_closed <= gap_r <= 32'sd0;
      end
      OP_RES_CLOSED: begin
        res_speed  <= '0;
        res_closed <= 1'b1;
      end
      OP_RES_FINAL: begin
        if (v_r[25]) begin
          res_speed <= '0;
        end else if (v_r > 26'sd65535) begin
          res_speed <= '1;
        end else begin
          res_speed <= v_r[15:0];
        end
        res_closed <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      next_speed <= res_speed;
      gap_closed <= res_closed;
    end
  end

  assign stat.mul_done   = mul_done;
  assign stat.div_done   = div_done;
  assign stat.stop_near  = stop_r && (gap_r <= 32'sd2);
  assign stat.gap_zero   = gap_r <= 32'sd0;
  assign stat.steps_done = step_cnt == n_val;
  assign stat.pow_done   = k_r == cfg.accel_exponent;
  assign stat.out_busy   = out_valid && !out_ready;

endmodule

`default_nettype wire

// ===== src/idm_ctrl.sv =====
// ============================================================================
// idm_ctrl
// Controller: steps one query through the sub-step sequence and launches
// the shared multiplier and divider.
// ============================================================================
`default_nettype none

module idm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output idm_pkg::dp_cmd_t       cmd,
  input  wire idm_pkg::dp_stat_t stat
);
  import idm_pkg::*;

  state_t state;
  state_t state_next;
  logic   launched;
  logic   launched_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  always_comb begin
    state_next    = state;
    launched_next = launched;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.mul_start = 1'b0;
    cmd.div_start = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_FAC;
        end
      end
      ST_FAC: begin
        if (stat.stop_near) begin
          cmd.op     = OP_RES_STOP;
          state_next = ST_OUT;
        end else begin
          cmd.op     = OP_FAC;
          state_next = ST_HW;
        end
      end
      ST_HW: begin
        cmd.op     = OP_HW;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        // Within the sub-steps, the gap is only checked at the start of a
        // sub-step, never after the last one.
        if (stat.steps_done) begin
          cmd.op     = OP_RES_FINAL;
          state_next = ST_OUT;
        end else if (stat.gap_zero) begin
          cmd.op     = OP_RES_CLOSED;
          state_next = ST_OUT;
        end else begin
          state_next = ST_VH;
        end
      end
      ST_VH, ST_VVL, ST_QQ, ST_ACC, ST_ACC_TS, ST_ADV_TS: begin
        unique case (state)
          ST_VH:     cmd.op = OP_VH;
          ST_VVL:    cmd.op = OP_VVL;
          ST_QQ:     cmd.op = OP_QQ;
          ST_ACC:    cmd.op = OP_ACC;
          ST_ACC_TS: cmd.op = OP_ACC_TS;
          default:   cmd.op = OP_ADV_TS;
        endcase
        cmd.mul_start = !launched;
        launched_next = 1'b1;
        if (stat.mul_done) begin
          launched_next = 1'b0;
          unique case (state)
            ST_VH:     state_next = ST_VVL;
            ST_VVL:    state_next = ST_BRAKE;
            ST_QQ:     state_next = ST_ACC;
            ST_ACC:    state_next = ST_ACC_TS;
            ST_ACC_TS: state_next = ST_DV;
            default:   state_next = ST_ADV;
          endcase
        end
      end
      ST_BRAKE, ST_Q, ST_R, ST_DV, ST_ADV: begin
        unique case (state)
          ST_BRAKE: cmd.op = OP_DIV_BRAKE;
          ST_Q:     cmd.op = OP_DIV_Q;
          ST_R:     cmd.op = OP_DIV_R;
          ST_DV:    cmd.op = OP_DIV_DV;
          default:  cmd.op = OP_DIV_ADV;
        endcase
        cmd.div_start = !launched;
        launched_next = 1'b1;
        if (stat.div_done) begin
          launched_next = 1'b0;
          unique case (state)
            ST_BRAKE: state_next = ST_Q;
            ST_Q:     state_next = ST_R;
            ST_R:     state_next = ST_PINIT;
            ST_DV:    state_next = ST_ADV_TS;
            default:  state_next = ST_CHECK;
          endcase
        end
      end
      ST_PINIT: begin
        cmd.op     = OP_P_INIT;
        state_next = ST_POW;
      end
      ST_POW: begin
        if (!launched && stat.pow_done) begin
          state_next = ST_QQ;
        end else begin
          cmd.op        = OP_PR;
          cmd.mul_start = !launched;
          launched_next = 1'b1;
          if (stat.mul_done) begin
            launched_next = 1'b0;
          end
        end
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/idm_car_following_speed.sv =====
// ============================================================================
// idm_car_following_speed
// Intelligent Driver Model speed step in Q.8 fixed point for one vehicle.
// ============================================================================
// Usage: a query word (cmd, ego_speed, gap_ahead, leader_speed,
// desired_speed, service_level) is taken on the input channel when in_valid
// and in_ready are both high. One result word (next_speed, gap_closed) is
// returned on the output channel for every query, in order.
// The block works on one query at a time. A query runs through a sequence
// of sub-steps, each of which uses one shared multiplier and one shared
// divider that makes one quotient bit per cycle. A stop query that is
// already within the stop threshold skips the sub-steps. The five divisions
// of each sub-step dominate the time that a query takes.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data, one register per cycle. The user must write them only while no
// query is in flight; the block itself does not enforce this.
// Reset restores every configuration register to its default and empties
// the block.
// The result sits in an output register: if the receiver stalls, the block
// still takes and works on the next query, and holds its finished result
// until the output register is free again.
// ============================================================================
`default_nettype none

module idm_car_following_speed #(
  parameter int MAX_SUBSTEPS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       cmd,
  input  wire logic [15:0]                ego_speed,
  input  wire logic signed [23:0]         gap_ahead,
  input  wire logic [15:0]                leader_speed,
  input  wire logic [15:0]                desired_speed,
  input  wire logic [8:0]                 service_level,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [15:0]                     next_speed,
  output logic                            gap_closed,
  input  wire logic                       cfg_we,
  input  wire logic [idm_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [idm_pkg::CFG_DW-1:0] cfg_data
);
  import idm_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Configuration registers. Each write keeps only the bits of the
  // register's own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_accel         <= 12'd666;
      cfg.brake_term        <= 14'd1751;
      cfg.headway_time      <= 12'd384;
      cfg.accel_exponent    <= 4'd4;
      cfg.min_gap           <= 13'd640;
      cfg.step_length       <= 12'd256;
      cfg.substeps          <= 5'd4;
      cfg.adaptation_factor <= 10'd256;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_MAX_ACCEL:      cfg.max_accel         <= cfg_data[11:0];
        REG_BRAKE_TERM:     cfg.brake_term        <= cfg_data[13:0];
        REG_HEADWAY_TIME:   cfg.headway_time      <= cfg_data[11:0];
        REG_ACCEL_EXPONENT: cfg.accel_exponent    <= cfg_data[3:0];
        REG_MIN_GAP:        cfg.min_gap           <= cfg_data[12:0];
        REG_STEP_LENGTH:    cfg.step_length       <= cfg_data[11:0];
        REG_SUBSTEPS:       cfg.substeps          <= cfg_data[4:0];
        REG_ADAPTATION:     cfg.adaptation_factor <= cfg_data[9:0];
      endcase
    end
  end

  // The controller sequences the sub-steps; the datapath holds the query and working values.
  idm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (dp_cmd),
    .stat     (dp_stat)
  );

  idm_dp #(
    .MAX_SUBSTEPS (MAX_SUBSTEPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .cmd_in        (cmd),
    .ego_speed     (ego_speed),
    .gap_ahead     (gap_ahead),
    .leader_speed  (leader_speed),
    .desired_speed (desired_speed),
    .service_level (service_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_speed    (next_speed),
    .gap_closed    (gap_closed)
  );

endmodule

`default_nettype wire
